// File: rtl/core/ctq_pkg.sv
`default_nettype none
package ctq_pkg;
    localparam int TIME_BITS = 32;
    localparam int SEQ_BITS  = 32;
    localparam int WAIT_BITS = 16;
    localparam int OP_BITS   = 2;
    localparam int CFG_IDX_BITS = 1;

    localparam logic [OP_BITS-1:0] OP_ADD   = 2'd0;
    localparam logic [OP_BITS-1:0] OP_POLL  = 2'd1;
    localparam logic [OP_BITS-1:0] OP_DEL   = 2'd2;
    localparam logic [OP_BITS-1:0] OP_CLEAR = 2'd3;

    localparam logic [CFG_IDX_BITS-1:0] REG_WAIT_TIME = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_KICK_MODE = 1'd1;

    // command broadcast to every cell for one cycle
    typedef struct packed {
        logic                 ins;      // sorted insert of key
        logic                 pop;      // shift everything one toward the head
        logic                 del;      // drop the first entry matching conn
        logic                 clr;      // empty all cells
        logic [TIME_BITS-1:0] key;
        logic [SEQ_BITS-1:0]  seq;
    } ctq_cmd_t;
endpackage
`default_nettype wire

// File: rtl/core/ctq_cell.sv
`default_nettype none
// one slot of the sorted row; cell 0 holds the earliest entry
module ctq_cell #(
    parameter int CONN_BITS = 10
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  ctq_pkg::ctq_cmd_t     cmd,
    input  wire [CONN_BITS-1:0]   cmd_conn,
    // neighbor toward the head
    input  wire                   prev_valid,
    input  wire                   prev_le,       // prev holds time <= key
    input  wire [31:0]            prev_time,
    input  wire [CONN_BITS-1:0]   prev_conn,
    input  wire [31:0]            prev_seq,
    input  wire [6:0]             prev_drop,     // nonzero when a match sits at or before this cell
    // neighbor toward the tail
    input  wire                   succ_valid,
    input  wire [31:0]            succ_time,
    input  wire [CONN_BITS-1:0]   succ_conn,
    input  wire [31:0]            succ_seq,
    output logic                  valid,
    output logic                  le,
    output logic [31:0]           time_q,
    output logic [CONN_BITS-1:0]  conn_q,
    output logic [31:0]           seq_q,
    output logic                  match
);
    import ctq_pkg::*;

    logic                 valid_reg, valid_next;
    logic [31:0]          time_reg, time_next;
    logic [CONN_BITS-1:0] conn_reg, conn_next;
    logic [31:0]          seq_reg, seq_next;
    logic                 here_le;

    assign here_le = valid_reg && (time_reg <= cmd.key);
    assign valid  = valid_reg;
    assign le     = here_le;
    assign time_q = time_reg;
    assign conn_q = conn_reg;
    assign seq_q  = seq_reg;
    assign match  = valid_reg && (conn_reg == cmd_conn);

    always_comb
    begin
        valid_next = valid_reg;
        time_next  = time_reg;
        conn_next  = conn_reg;
        seq_next   = seq_reg;
        if (cmd.clr)
        begin
            valid_next = 1'b0;
        end
        else if (cmd.pop)
        begin
            valid_next = succ_valid;
            time_next  = succ_time;
            conn_next  = succ_conn;
            seq_next   = succ_seq;
        end
        else if (cmd.ins)
        begin
            // stable insert: goes behind every entry <= key
            if (!here_le && prev_le)
            begin
                valid_next = 1'b1;
                time_next  = cmd.key;
                conn_next  = cmd_conn;
                seq_next   = cmd.seq;
            end
            else if (!here_le && prev_valid)
            begin
                valid_next = 1'b1;
                time_next  = prev_time;
                conn_next  = prev_conn;
                seq_next   = prev_seq;
            end
        end
        else if (cmd.del)
        begin
            // one delete step removes the first match and closes the gap
            if (prev_drop != 7'd0)
            begin
                valid_next = succ_valid;
                time_next  = succ_time;
                conn_next  = succ_conn;
                seq_next   = succ_seq;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        time_reg <= time_next;
        conn_reg <= conn_next;
        seq_reg  <= seq_next;
    end
endmodule
`default_nettype wire

// File: rtl/core/connection_timeout_queue_core.sv
`default_nettype none
// connection timeout queue: entries sorted by expiry in a row of cells,
// earliest at cell 0, equal expiries in order of arrival.
// channels: cfg (index, data) writes wait_time (0) and kick_mode (1).
// s_axis beat: operation add/poll/delete/clear with time, conn and sequence.
// m_axis beat: one result per operation (found, popped entry, count,
// earliest expiry, overflow).
// steps from accept to result: add and clear execute once, a dropping
// poll pops the head, a re-arming poll pops it and inserts it again,
// delete repeats until no match is left: each cycle the cells shift out
// the first matching entry, so the delete loop sets the rate. the next
// beat is taken in the cycle after the result is loaded, not before.
// the result is held in an output register; a finished result is loaded
// once that register is free or being taken, so a stalled receiver
// holds the block with one result in the register and one waiting.
// reset empties the row and clears both config registers; the entry
// payload is not cleared, only the per-cell valid bits.
module connection_timeout_queue_core #(
    parameter int QUEUE_DEPTH  = 64,
    parameter int CONN_ID_BITS = 10
) (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        cfg_valid,
    output logic       cfg_ready,
    input  wire [0:0]  cfg_index,
    input  wire [15:0] cfg_data,
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    // operation, now_time, conn_id, sequence_req (zero padded)
    input  wire [((2+32+CONN_ID_BITS+32+7)/8)*8-1:0] s_axis_tdata,
    output logic       m_axis_tvalid,
    input  wire        m_axis_tready,
    // found, out_conn, out_sequence, queue_count, earliest_time, overflow
    output logic [((1+CONN_ID_BITS+32+7+32+1+7)/8)*8-1:0] m_axis_tdata
);
    import ctq_pkg::*;

    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
    localparam int IN_W  = ((2+32+CONN_ID_BITS+32+7)/8)*8;
    localparam int OUT_W = ((1+CONN_ID_BITS+32+7+32+1+7)/8)*8;
    localparam int OUT_USED = 1 + CONN_ID_BITS + 32 + 7 + 32 + 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_DEL  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0] st_reg, st_next;
    logic [15:0] wait_reg;
    logic        kick_reg;

    logic [1:0]              op_reg;
    logic [31:0]             now_reg;
    logic [CONN_ID_BITS-1:0] cid_reg;
    logic [31:0]             sq_reg;
    logic                    rearm_reg;
    logic                    found_reg, ovf_reg;
    logic [CONN_ID_BITS-1:0] oconn_reg;
    logic [31:0]             oseq_reg;
    logic [CNT_BITS-1:0]     cnt_reg, cnt_next;

    logic                    mv_reg;
    logic [OUT_W-1:0]        md_reg;

    logic [32:0] sum;
    logic [31:0] sat;
    assign sum = {1'b0, now_reg} + {17'd0, wait_reg};
    assign sat = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

    ctq_cmd_t                cmd;
    logic [CONN_ID_BITS-1:0] cmd_conn;

    logic                    c_valid [QUEUE_DEPTH];
    logic                    c_le    [QUEUE_DEPTH];
    logic [31:0]             c_time  [QUEUE_DEPTH];
    logic [CONN_ID_BITS-1:0] c_conn  [QUEUE_DEPTH];
    logic [31:0]             c_seq   [QUEUE_DEPTH];
    logic                    c_match [QUEUE_DEPTH];
    logic [6:0]              c_drop  [QUEUE_DEPTH];
    logic                    any_match;

    // c_drop[i] nonzero when a match sits at or before cell i
    always_comb
    begin
        c_drop[0] = {6'd0, c_match[0]};
        for (int i = 1; i < QUEUE_DEPTH; i++)
            c_drop[i] = (c_drop[i-1] != 7'd0 || c_match[i]) ? 7'd1 : 7'd0;
    end
    assign any_match = c_drop[QUEUE_DEPTH-1] != 7'd0;

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++)
        begin : g_cell
            ctq_cell #(.CONN_BITS(CONN_ID_BITS)) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (cmd),
                .cmd_conn   (cmd_conn),
                .prev_valid ((g == 0) ? 1'b0 : c_valid[(g == 0) ? 0 : g-1]),
                .prev_le    ((g == 0) ? 1'b1 : c_le[(g == 0) ? 0 : g-1]),
                .prev_time  (c_time[(g == 0) ? 0 : g-1]),
                .prev_conn  (c_conn[(g == 0) ? 0 : g-1]),
                .prev_seq   (c_seq[(g == 0) ? 0 : g-1]),
                .prev_drop  (c_drop[g]),
                .succ_valid ((g == QUEUE_DEPTH-1) ? 1'b0
                             : c_valid[(g == QUEUE_DEPTH-1) ? g : g+1]),
                .succ_time  (c_time[(g == QUEUE_DEPTH-1) ? g : g+1]),
                .succ_conn  (c_conn[(g == QUEUE_DEPTH-1) ? g : g+1]),
                .succ_seq   (c_seq[(g == QUEUE_DEPTH-1) ? g : g+1]),
                .valid      (c_valid[g]),
                .le         (c_le[g]),
                .time_q     (c_time[g]),
                .conn_q     (c_conn[g]),
                .seq_q      (c_seq[g]),
                .match      (c_match[g])
            );
        end
    endgenerate

    logic out_free;
    logic full, due;
    assign out_free      = !mv_reg || m_axis_tready;
    assign s_axis_tready = (st_reg == ST_IDLE);
    assign cfg_ready     = (st_reg == ST_IDLE);
    assign full = (cnt_reg == CNT_BITS'(QUEUE_DEPTH));
    assign due  = c_valid[0] && (c_time[0] <= now_reg);

    always_comb
    begin
        cmd       = '0;
        cmd.key   = sat;
        cmd.seq   = rearm_reg ? oseq_reg : sq_reg;
        cmd_conn  = rearm_reg ? oconn_reg : cid_reg;
        cnt_next  = cnt_reg;
        st_next   = st_reg;
        unique case (st_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                    st_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                st_next = ST_DONE;
                if (rearm_reg)
                begin
                    cmd.ins  = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
                else
                begin
                    unique case (op_reg)
                        OP_ADD:
                        begin
                            if (!full)
                            begin
                                cmd.ins  = 1'b1;
                                cnt_next = cnt_reg + 1'b1;
                            end
                        end
                        OP_POLL:
                        begin
                            if (due)
                            begin
                                cmd.pop  = 1'b1;
                                cnt_next = cnt_reg - 1'b1;
                                if (!kick_reg)
                                    st_next = ST_EXEC;
                            end
                        end
                        OP_DEL:
                            st_next = ST_DEL;
                        OP_CLEAR:
                        begin
                            cmd.clr  = 1'b1;
                            cnt_next = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_DEL:
            begin
                if (any_match)
                begin
                    cmd.del  = 1'b1;
                    cnt_next = cnt_reg - 1'b1;
                end
                else
                    st_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    st_next = ST_IDLE;
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= ST_IDLE;
            wait_reg  <= '0;
            kick_reg  <= 1'b0;
            cnt_reg   <= '0;
            mv_reg    <= 1'b0;
            rearm_reg <= 1'b0;
        end
        else
        begin
            st_reg  <= st_next;
            cnt_reg <= cnt_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_WAIT_TIME: wait_reg <= cfg_data;
                    REG_KICK_MODE: kick_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            if (st_reg == ST_IDLE)
                rearm_reg <= 1'b0;
            else if (st_reg == ST_EXEC)
                rearm_reg <= !rearm_reg && op_reg == OP_POLL && due && !kick_reg;
            if (st_reg == ST_DONE && out_free)
                mv_reg <= 1'b1;
            else if (m_axis_tready)
                mv_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            op_reg    <= s_axis_tdata[1:0];
            now_reg   <= s_axis_tdata[33:2];
            cid_reg   <= s_axis_tdata[34 +: CONN_ID_BITS];
            sq_reg    <= s_axis_tdata[34+CONN_ID_BITS +: 32];
            found_reg <= 1'b0;
            ovf_reg   <= 1'b0;
            oconn_reg <= '0;
            oseq_reg  <= '0;
        end
        else if (st_reg == ST_EXEC && !rearm_reg)
        begin
            if (op_reg == OP_ADD)
                ovf_reg <= full;
            if (op_reg == OP_POLL && due)
            begin
                found_reg <= 1'b1;
                oconn_reg <= c_conn[0];
                oseq_reg  <= c_seq[0];
            end
        end
        if (st_reg == ST_DONE && out_free)
            md_reg <= {{(OUT_W-OUT_USED){1'b0}}, ovf_reg,
                       (c_valid[0] ? c_time[0] : 32'd0),
                       7'(cnt_reg), oseq_reg, oconn_reg, found_reg};
    end

    assign m_axis_tvalid = mv_reg;
    assign m_axis_tdata  = md_reg;

    logic unused_in;
    assign unused_in = ^s_axis_tdata[IN_W-1:34+CONN_ID_BITS+32] ^ ^cfg_data[15:1];

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_BITS'(QUEUE_DEPTH))
        else $error("count beyond depth");
    a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != '0) == c_valid[0])
        else $error("head valid disagrees with count");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");
endmodule
`default_nettype wire
